// File: design/owrs_pkg.sv
package owrs_pkg;

  localparam int RomWidth = 64;
  localparam int PosWidth = 7;
  localparam int FamWidth = 4;
  localparam logic [7:0] CrcPoly = 8'h8C;
  localparam logic [PosWidth-1:0] FamilyLimit = 7'd9;
  localparam logic [PosWidth-1:0] EndPosition = 7'd65;
  localparam logic [PosWidth-1:0] FirstPosition = 7'd1;

  localparam logic [1:0] MODE_RESTART = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_BIT_PAIR = 2'd2;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_FOUND = 3'd1,
    ST_NO_DEVICES = 3'd2,
    ST_BAD_CRC = 3'd3,
    ST_ZERO_FAMILY = 3'd4,
    ST_NO_PRESENCE = 3'd5,
    ST_DONE = 3'd6,
    ST_NO_PASS = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       presence;
    logic       true_bit;
    logic       complement_bit;
  } item_t;

  typedef struct packed {
    logic                write_bit;
    status_t             status;
    logic [RomWidth-1:0] rom_id;
    logic [FamWidth-1:0] family_discrepancy;
    logic                all_found;
  } result_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: design/owrs_engine.sv
module owrs_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  owrs_pkg::item_t   item,
  output owrs_pkg::result_t res
);

  logic [owrs_pkg::RomWidth-1:0] rom_store, rom_store_next;
  logic [7:0]                    byte_accum, byte_accum_next;
  logic [owrs_pkg::PosWidth-1:0] bit_position, bit_position_next;
  logic [owrs_pkg::PosWidth-1:0] zero_branch_pos, zero_branch_pos_next;
  logic [owrs_pkg::PosWidth-1:0] prior_discrepancy, prior_discrepancy_next;
  logic [owrs_pkg::FamWidth-1:0] family_disc, family_disc_next;
  logic [7:0]                    crc_reg, crc_reg_next;
  logic                          done_flag, done_flag_next;
  logic                          pass_active, pass_active_next;

  logic [5:0]        idx;
  logic              dir;
  logic [7:0]        acc_set;
  owrs_pkg::status_t status;
  logic              wbit;

  assign idx = 6'(bit_position - owrs_pkg::FirstPosition);

  always_comb begin
    rom_store_next = rom_store;
    byte_accum_next = byte_accum;
    bit_position_next = bit_position;
    zero_branch_pos_next = zero_branch_pos;
    prior_discrepancy_next = prior_discrepancy;
    family_disc_next = family_disc;
    crc_reg_next = crc_reg;
    done_flag_next = done_flag;
    pass_active_next = pass_active;
    status = owrs_pkg::ST_OK;
    wbit = 1'b0;
    dir = 1'b0;
    acc_set = byte_accum;
    case (item.mode)
      owrs_pkg::MODE_RESTART: begin
        prior_discrepancy_next = '0;
        family_disc_next = '0;
        done_flag_next = 1'b0;
        pass_active_next = 1'b0;
      end
      owrs_pkg::MODE_START: begin
        if (done_flag) begin
          pass_active_next = 1'b0;
          status = owrs_pkg::ST_DONE;
        end else if (!item.presence) begin
          pass_active_next = 1'b0;
          status = owrs_pkg::ST_NO_PRESENCE;
        end else begin
          bit_position_next = owrs_pkg::FirstPosition;
          zero_branch_pos_next = '0;
          byte_accum_next = '0;
          crc_reg_next = '0;
          pass_active_next = 1'b1;
        end
      end
      owrs_pkg::MODE_BIT_PAIR: begin
        if (!pass_active) begin
          status = owrs_pkg::ST_NO_PASS;
        end else if (item.true_bit && item.complement_bit) begin
          pass_active_next = 1'b0;
          status = owrs_pkg::ST_NO_DEVICES;
        end else begin
          if (item.true_bit != item.complement_bit) begin
            dir = item.true_bit;
          end else begin
            if (bit_position < prior_discrepancy) begin
              dir = rom_store[idx];
            end else begin
              dir = (bit_position == prior_discrepancy);
            end
            if (!dir) begin
              zero_branch_pos_next = bit_position;
              if (bit_position < owrs_pkg::FamilyLimit) begin
                family_disc_next = bit_position[owrs_pkg::FamWidth-1:0];
              end
            end
          end
          if (dir) begin
            acc_set[idx[2:0]] = 1'b1;
          end
          byte_accum_next = acc_set;
          wbit = dir;
          if (idx[2:0] == 3'd7) begin
            crc_reg_next = owrs_pkg::crc8_byte(crc_reg, acc_set);
            rom_store_next[{idx[5:3], 3'd0} +: 8] = acc_set;
            byte_accum_next = '0;
          end
          bit_position_next = bit_position + 7'd1;
          if (bit_position_next >= owrs_pkg::EndPosition) begin
            pass_active_next = 1'b0;
            if (crc_reg_next != 8'd0) begin
              status = owrs_pkg::ST_BAD_CRC;
            end else if (rom_store_next[7:0] == 8'd0) begin
              status = owrs_pkg::ST_ZERO_FAMILY;
            end else begin
              prior_discrepancy_next = zero_branch_pos_next;
              if (zero_branch_pos_next == '0) begin
                done_flag_next = 1'b1;
              end
              status = owrs_pkg::ST_FOUND;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res.write_bit = wbit;
  assign res.status = status;
  assign res.rom_id = rom_store_next;
  assign res.family_discrepancy = family_disc_next;
  assign res.all_found = done_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_store <= '0;
      byte_accum <= '0;
      bit_position <= owrs_pkg::FirstPosition;
      zero_branch_pos <= '0;
      prior_discrepancy <= '0;
      family_disc <= '0;
      crc_reg <= '0;
      done_flag <= 1'b0;
      pass_active <= 1'b0;
    end else if (fire) begin
      rom_store <= rom_store_next;
      byte_accum <= byte_accum_next;
      bit_position <= bit_position_next;
      zero_branch_pos <= zero_branch_pos_next;
      prior_discrepancy <= prior_discrepancy_next;
      family_disc <= family_disc_next;
      crc_reg <= crc_reg_next;
      done_flag <= done_flag_next;
      pass_active <= pass_active_next;
    end
  end

  a_restart_closes_pass: assert property (@(posedge clk) disable iff (rst)
    fire && item.mode == owrs_pkg::MODE_RESTART |=> !pass_active)
    else $error("Pass still open after a restart.");

  a_done_means_no_discrepancy: assert property (@(posedge clk) disable iff (rst)
    done_flag |-> prior_discrepancy == '0)
    else $error("All-found flag set with a pending discrepancy.");

  a_position_in_range: assert property (@(posedge clk) disable iff (rst)
    pass_active |-> bit_position != '0 && bit_position < owrs_pkg::EndPosition)
    else $error("Bit position out of range during a pass.");

  a_write_bit_source: assert property (@(posedge clk) disable iff (rst)
    fire && res.write_bit |-> item.mode == owrs_pkg::MODE_BIT_PAIR && pass_active)
    else $error("Direction bit driven outside a bit-pair transfer.");

endmodule

// File: design/one_wire_rom_search_unit.sv
// Bit-pair engine for the 1-Wire ROM search. The host handles bus timing, the bus reset and the
// search command, and sends one item per step: restart, start of a pass with the presence flag,
// or a bit pair read from the bus, which returns the direction bit to write back. Every item
// yields exactly one result. An item is registered on entry, and its result is computed
// combinationally from that register and the search state and placed in an output register,
// so the unit takes one item per clock cycle; the only stalls come from the result side. The ROM
// code, family-byte discrepancy and all-found flag shown on each result are the values after
// that item.
module one_wire_rom_search_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic        presence,
  input  logic        true_bit,
  input  logic        complement_bit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_bit,
  output logic [2:0]  status,
  output logic [63:0] rom_id,
  output logic [3:0]  family_discrepancy,
  output logic        all_found
);

  logic              item_valid;
  owrs_pkg::item_t   item;
  owrs_pkg::result_t res;
  owrs_pkg::result_t res_reg;
  logic              advance;
  logic              fire;
  logic              take;

  assign advance = !out_valid || !out_stall;
  assign fire = item_valid && advance;
  assign in_stall = item_valid && !advance;
  assign take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.mode <= mode;
      item.presence <= presence;
      item.true_bit <= true_bit;
      item.complement_bit <= complement_bit;
    end
  end

  owrs_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_reg <= res;
    end
  end

  assign write_bit = res_reg.write_bit;
  assign status = res_reg.status;
  assign rom_id = res_reg.rom_id;
  assign family_discrepancy = res_reg.family_discrepancy;
  assign all_found = res_reg.all_found;

endmodule

// File: sim/one_wire_rom_search_unit_tb.sv
`timescale 1ns / 1ps

module one_wire_rom_search_unit_tb;

  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int RandomItems = 400;

  typedef struct packed {
    logic [63:0] rom;
    logic [7:0]  acc;
    logic [6:0]  pos;
    logic [6:0]  zero_branch;
    logic [6:0]  prior;
    logic [3:0]  fam;
    logic [7:0]  crc;
    logic        done;
    logic        active;
  } search_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = owrs_pkg::MODE_RESTART;
  logic        presence = 1'b0;
  logic        true_bit = 1'b0;
  logic        complement_bit = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        write_bit;
  logic [2:0]  status;
  logic [63:0] rom_id;
  logic [3:0]  family_discrepancy;
  logic        all_found;

  owrs_pkg::item_t   queued_items[$];
  bit                drain_flags[$];
  owrs_pkg::result_t awaited_results[$];
  logic [63:0]       devices[$];
  search_state_t     gen_state;
  search_state_t     chk_state;
  owrs_pkg::result_t due;
  owrs_pkg::item_t   next_item;
  logic              in_fire = 1'b0;
  logic              last_found = 1'b0;
  int                errors = 0;
  int                sent_count = 0;
  int                total_items = 0;
  int                send_pct = 0;
  int                recv_pct = 0;

  one_wire_rom_search_unit u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .presence(presence),
    .true_bit(true_bit),
    .complement_bit(complement_bit),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .write_bit(write_bit),
    .status(status),
    .rom_id(rom_id),
    .family_discrepancy(family_discrepancy),
    .all_found(all_found)
  );

  always #4 clk = ~clk;

  // Reflected CRC-8, one data bit at a time, LSB first.
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ data[i]) begin
        c = (c >> 1) ^ owrs_pkg::CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic search_state_t fresh_state();
    search_state_t s;
    s = '0;
    s.pos = owrs_pkg::FirstPosition;
    return s;
  endfunction

  function automatic owrs_pkg::result_t search_step(inout search_state_t s,
                                                    input owrs_pkg::item_t it);
    owrs_pkg::result_t r;
    logic [5:0]        idx;
    logic              dir;
    r = '0;
    r.status = owrs_pkg::ST_OK;
    idx = '0;
    dir = 1'b0;
    case (it.mode)
      owrs_pkg::MODE_RESTART: begin
        s.prior = '0;
        s.fam = '0;
        s.done = 1'b0;
        s.active = 1'b0;
      end
      owrs_pkg::MODE_START: begin
        if (s.done) begin
          s.active = 1'b0;
          r.status = owrs_pkg::ST_DONE;
        end else if (!it.presence) begin
          s.active = 1'b0;
          r.status = owrs_pkg::ST_NO_PRESENCE;
        end else begin
          s.pos = owrs_pkg::FirstPosition;
          s.zero_branch = '0;
          s.acc = '0;
          s.crc = '0;
          s.active = 1'b1;
        end
      end
      owrs_pkg::MODE_BIT_PAIR: begin
        if (!s.active) begin
          r.status = owrs_pkg::ST_NO_PASS;
        end else if (it.true_bit && it.complement_bit) begin
          s.active = 1'b0;
          r.status = owrs_pkg::ST_NO_DEVICES;
        end else begin
          idx = s.pos[5:0] - 6'd1;
          if (it.true_bit != it.complement_bit) begin
            dir = it.true_bit;
          end else begin
            if (s.pos < s.prior) begin
              dir = s.rom[idx];
            end else begin
              dir = (s.pos == s.prior);
            end
            if (!dir) begin
              s.zero_branch = s.pos;
              if (s.pos < owrs_pkg::FamilyLimit) begin
                s.fam = s.pos[3:0];
              end
            end
          end
          if (dir) begin
            s.acc[idx[2:0]] = 1'b1;
          end
          r.write_bit = dir;
          if (idx[2:0] == 3'd7) begin
            s.crc = crc_fold(s.crc, s.acc);
            s.rom[{idx[5:3], 3'b000} +: 8] = s.acc;
            s.acc = '0;
          end
          s.pos = s.pos + 7'd1;
          if (s.pos >= owrs_pkg::EndPosition) begin
            s.active = 1'b0;
            if (s.crc != 8'd0) begin
              r.status = owrs_pkg::ST_BAD_CRC;
            end else if (s.rom[7:0] == 8'd0) begin
              r.status = owrs_pkg::ST_ZERO_FAMILY;
            end else begin
              s.prior = s.zero_branch;
              if (s.prior == 7'd0) begin
                s.done = 1'b1;
              end
              r.status = owrs_pkg::ST_FOUND;
            end
          end
        end
      end
      default: ;
    endcase
    r.rom_id = s.rom;
    r.family_discrepancy = s.fam;
    r.all_found = s.done;
    return r;
  endfunction

  task automatic queue_item(input logic [1:0] m, input logic p, input logic t, input logic c,
                            input bit drain, output owrs_pkg::result_t res);
    owrs_pkg::item_t it;
    it = {m, p, t, c};
    res = search_step(gen_state, it);
    queued_items.push_back(it);
    drain_flags.push_back(drain);
  endtask

  task automatic new_population();
    int          n;
    logic [63:0] rom;
    logic [7:0]  c;
    devices.delete();
    n = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 4);
    for (int d = 0; d < n; d++) begin
      rom[7:0] = ($urandom_range(99) < 10) ? 8'h00 : 8'($urandom_range(1, 255));
      rom[39:8] = $urandom;
      rom[55:40] = 16'($urandom);
      c = 8'd0;
      for (int b = 0; b < 7; b++) begin
        c = crc_fold(c, rom[b*8 +: 8]);
      end
      if ($urandom_range(99) < 10) begin
        c = c ^ 8'(1 << $urandom_range(7));
      end
      rom[63:56] = c;
      devices.push_back(rom);
    end
  endtask

  // One search pass against the simulated devices on the bus; the direction
  // bits come from the generator's copy of the search state.
  task automatic run_pass();
    owrs_pkg::result_t res;
    bit                alive [0:3];
    logic              all_t;
    logic              all_c;
    int                stop_at;
    int                corrupt_at;
    queue_item(owrs_pkg::MODE_START, ($urandom_range(99) < 90), 1'($urandom_range(1)),
               1'($urandom_range(1)), ($urandom_range(99) < 3), res);
    last_found = 1'b0;
    if (res.status != owrs_pkg::ST_OK) begin
      return;
    end
    stop_at = ($urandom_range(99) < 8) ? $urandom_range(1, 64) : 65;
    corrupt_at = ($urandom_range(99) < 8) ? $urandom_range(1, 64) : 0;
    for (int d = 0; d < 4; d++) begin
      alive[d] = (d < devices.size());
    end
    for (int b = 1; b <= 64; b++) begin
      if (b >= stop_at) begin
        return;
      end
      all_t = 1'b1;
      all_c = 1'b1;
      for (int d = 0; d < devices.size(); d++) begin
        if (alive[d]) begin
          all_t = all_t & devices[d][b-1];
          all_c = all_c & ~devices[d][b-1];
        end
      end
      if (b == corrupt_at) begin
        all_t = 1'($urandom_range(1));
        all_c = 1'($urandom_range(1));
      end
      queue_item(owrs_pkg::MODE_BIT_PAIR, 1'($urandom_range(1)), all_t, all_c, 1'b0, res);
      if (res.status == owrs_pkg::ST_NO_DEVICES) begin
        return;
      end
      for (int d = 0; d < devices.size(); d++) begin
        if (devices[d][b-1] != res.write_bit) begin
          alive[d] = 1'b0;
        end
      end
    end
    last_found = (res.status == owrs_pkg::ST_FOUND);
  endtask

  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
    end
  endtask

  always @(negedge clk) begin
    if (sent_count * 3 < total_items) begin
      send_pct = 28;
      recv_pct = 57;
    end else if (sent_count * 3 < total_items * 2) begin
      send_pct = 57;
      recv_pct = 28;
    end else begin
      send_pct = 0;
      recv_pct = 0;
    end
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
      if (!in_valid || in_fire) begin
        if (queued_items.size() != 0 && !(drain_flags[0] && awaited_results.size() != 0) &&
            $urandom_range(99) >= send_pct) begin
          next_item = queued_items.pop_front();
          void'(drain_flags.pop_front());
          mode <= next_item.mode;
          presence <= next_item.presence;
          true_bit <= next_item.true_bit;
          complement_bit <= next_item.complement_bit;
          in_valid <= 1'b1;
          sent_count++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        awaited_results.push_back(search_step(chk_state,
                                              {mode, presence, true_bit, complement_bit}));
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: result transfer with none awaited, actual status %0d", $time, status);
        end else begin
          due = awaited_results.pop_front();
          check_field("write_bit", 64'(due.write_bit), 64'(write_bit));
          check_field("status", 64'(due.status), 64'(status));
          check_field("rom_id", due.rom_id, rom_id);
          check_field("family_discrepancy", 64'(due.family_discrepancy),
                      64'(family_discrepancy));
          check_field("all_found", 64'(due.all_found), 64'(all_found));
        end
      end
    end
  end

  initial begin
    owrs_pkg::result_t res;
    gen_state = fresh_state();
    chk_state = fresh_state();

    queue_item(owrs_pkg::MODE_BIT_PAIR, 1'b1, 1'b1, 1'b0, 1'b0, res);
    queue_item(MODE_NOP, 1'b1, 1'b1, 1'b1, 1'b0, res);
    queue_item(owrs_pkg::MODE_START, 1'b0, 1'b1, 1'b1, 1'b0, res);
    queue_item(owrs_pkg::MODE_START, 1'b1, 1'b0, 1'b0, 1'b0, res);
    queue_item(owrs_pkg::MODE_BIT_PAIR, 1'b0, 1'b0, 1'b1, 1'b0, res);
    queue_item(owrs_pkg::MODE_BIT_PAIR, 1'b0, 1'b1, 1'b0, 1'b0, res);
    queue_item(owrs_pkg::MODE_BIT_PAIR, 1'b1, 1'b0, 1'b0, 1'b0, res);
    queue_item(owrs_pkg::MODE_START, 1'b1, 1'b1, 1'b1, 1'b0, res);
    queue_item(owrs_pkg::MODE_BIT_PAIR, 1'b0, 1'b0, 1'b0, 1'b0, res);
    queue_item(owrs_pkg::MODE_BIT_PAIR, 1'b0, 1'b1, 1'b1, 1'b0, res);
    queue_item(owrs_pkg::MODE_BIT_PAIR, 1'b0, 1'b0, 1'b0, 1'b0, res);
    queue_item(owrs_pkg::MODE_RESTART, 1'b1, 1'b1, 1'b1, 1'b1, res);
    queue_item(MODE_NOP, 1'b0, 1'b0, 1'b0, 1'b0, res);
    queue_item(owrs_pkg::MODE_START, 1'b1, 1'b0, 1'b0, 1'b0, res);
    for (int b = 0; b < 8; b++) begin
      queue_item(owrs_pkg::MODE_BIT_PAIR, 1'b0, 1'b1, 1'b0, 1'b0, res);
    end
    queue_item(owrs_pkg::MODE_RESTART, 1'b0, 1'b0, 1'b0, 1'b0, res);

    total_items = queued_items.size() + RandomItems;
    new_population();
    while (queued_items.size() < total_items) begin
      if (gen_state.done && $urandom_range(1)) begin
        queue_item(owrs_pkg::MODE_START, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'b0, res);
      end
      if (gen_state.done || (!last_found && $urandom_range(1)) || $urandom_range(99) < 10) begin
        queue_item(owrs_pkg::MODE_RESTART, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'b0, res);
        new_population();
      end
      if ($urandom_range(99) < 75) begin
        run_pass();
      end else begin
        repeat ($urandom_range(1, 3)) begin
          queue_item(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'b0, res);
        end
        last_found = 1'b0;
      end
    end
    total_items = queued_items.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (queued_items.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: run timed out", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
